// ===== src/escb_pkg.sv =====
// Shared types and constants for the escape-byte LZ compressor.
// No dependencies.
package escb_pkg;

  localparam int WINDOW       = 254;
  localparam int RING_DEPTH   = 512;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int HEADER_BYTES = 12;
  localparam int MIN_BACKREF  = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== src/escb_fifo.sv =====
// Front command queue: accepts input items and holds them for the encoder.
// Depends on escb_pkg.
module escb_fifo
  import escb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_stall,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_stall = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/escb_back.sv =====
// Encoder back end: history ring, match search and token output register.
// Depends on escb_pkg.
module escb_back
  import escb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        escape_write,
  input  logic [7:0]  escape_byte,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_count,
  output logic [7:0]  out_first,
  output logic [7:0]  out_second,
  output logic [7:0]  out_third,
  output logic        done_res,
  output logic [31:0] raw_total,
  output logic [31:0] packed_total,
  output logic        overflow
);

  typedef enum logic [2:0] {
    S_IDLE, S_LIT_RD, S_LIT, S_DNEXT, S_RD, S_CMP, S_EMIT, S_OUT
  } state_t;

  state_t      state;
  logic [7:0]  ring [RING_DEPTH];
  logic [7:0]  rd_a;
  logic [7:0]  rd_b;
  logic [7:0]  esc;
  logic [31:0] wp;
  logic [31:0] ep;
  logic [32:0] packed_cnt;
  logic        flushing;
  logic [7:0]  avail;
  logic [7:0]  lit;
  logic [7:0]  d;
  logic [7:0]  n;
  logic [7:0]  best;
  logic [7:0]  best_d;

  logic [RING_AW-1:0] addr_a;
  logic [RING_AW-1:0] addr_b;
  logic               ring_we;
  logic [31:0]        wp_next;
  logic [31:0]        fill_next;
  logic [31:0]        fill;
  logic [7:0]         hist;
  logic [7:0]         limit;
  logic [8:0]         n_inc;
  logic [7:0]         len;
  logic [1:0]         add_n;
  logic [33:0]        packed_sum;
  logic [32:0]        packed_next;
  logic [7:0]         off;

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign ring_we   = cmd_pop && (cmd.op == OP_APPEND) && !flushing;
  assign wp_next   = wp + 32'd1;
  assign fill_next = wp_next - ep;
  assign fill      = wp - ep;
  assign hist      = (ep < 32'(WINDOW)) ? ep[7:0] : 8'(WINDOW);
  assign limit     = (d < avail) ? d : avail;
  assign n_inc     = {1'b0, n} + 9'd1;
  assign len       = (rd_a == rd_b) ? n_inc[7:0] : n;
  assign addr_a    = ep[RING_AW-1:0] - RING_AW'(d) + RING_AW'(n);
  assign addr_b    = ep[RING_AW-1:0] + RING_AW'(n);
  assign add_n     = (best >= 8'(MIN_BACKREF)) ? 2'd3 : ((lit == esc) ? 2'd2 : 2'd1);
  assign packed_sum  = {1'b0, packed_cnt} + 34'(add_n);
  assign packed_next = (packed_sum > 34'h1_0000_0000) ? 33'h1_0000_0000 : packed_sum[32:0];
  assign off       = (esc <= best_d) ? best_d + 8'd1 : best_d;

  always_ff @(posedge clk) begin
    if (ring_we) ring[wp[RING_AW-1:0]] <= cmd.data;
    rd_a <= ring[addr_a];
    rd_b <= ring[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= '0;
    end else if (escape_write) begin
      esc <= escape_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wp           <= '0;
      ep           <= '0;
      packed_cnt   <= 33'(HEADER_BYTES);
      flushing     <= 1'b0;
      out_valid    <= 1'b0;
      avail        <= '0;
      lit          <= '0;
      d            <= '0;
      n            <= '0;
      best         <= '0;
      best_d       <= '0;
      out_count    <= '0;
      out_first    <= '0;
      out_second   <= '0;
      out_third    <= '0;
      done_res     <= 1'b0;
      raw_total    <= '0;
      packed_total <= '0;
      overflow     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            n <= '0;
            if (cmd.op == OP_APPEND) begin
              if (!flushing) begin
                wp <= wp_next;
                if (fill_next >= 32'(WINDOW)) begin
                  avail <= fill_next[7:0];
                  state <= S_LIT_RD;
                end
              end
            end else begin
              if (ep != wp) begin
                flushing <= 1'b1;
                avail    <= fill[7:0];
                state    <= S_LIT_RD;
              end else begin
                out_count    <= '0;
                out_first    <= '0;
                out_second   <= '0;
                out_third    <= '0;
                done_res     <= 1'b1;
                raw_total    <= wp;
                packed_total <= packed_cnt[32] ? 32'd0 : packed_cnt[31:0];
                overflow     <= packed_cnt[32];
                out_valid    <= 1'b1;
                wp           <= '0;
                ep           <= '0;
                packed_cnt   <= 33'(HEADER_BYTES);
                flushing     <= 1'b0;
                state        <= S_OUT;
              end
            end
          end
        end
        S_LIT_RD: state <= S_LIT;
        S_LIT: begin
          lit    <= rd_b;
          best   <= '0;
          best_d <= '0;
          d      <= 8'd1;
          state  <= (hist == '0) ? S_EMIT : S_DNEXT;
        end
        S_DNEXT: begin
          if (limit <= best) begin
            if (d == hist) state <= S_EMIT;
            else d <= d + 8'd1;
          end else begin
            n     <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if ((rd_a == rd_b) && (n_inc < {1'b0, limit})) begin
            n     <= n_inc[7:0];
            state <= S_RD;
          end else begin
            if (len > best) begin
              best   <= len;
              best_d <= d;
            end
            if (d == hist) begin
              state <= S_EMIT;
            end else begin
              d     <= d + 8'd1;
              state <= S_DNEXT;
            end
          end
        end
        S_EMIT: begin
          done_res     <= 1'b0;
          raw_total    <= '0;
          packed_total <= '0;
          overflow     <= 1'b0;
          packed_cnt   <= packed_next;
          if (best >= 8'(MIN_BACKREF)) begin
            out_count  <= 2'd3;
            out_first  <= esc;
            out_second <= off;
            out_third  <= best;
            ep         <= ep + 32'(best);
          end else begin
            out_count  <= add_n;
            out_first  <= lit;
            out_second <= (lit == esc) ? lit : 8'd0;
            out_third  <= '0;
            ep         <= ep + 32'd1;
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/escape_byte_lz_compressor.sv =====
// Top level of the escape-byte LZ compressor: command queue plus encoder.
// Depends on escb_pkg, escb_fifo and escb_back.
//
// Greedy LZ77 with one escape byte. Appends that do not yet fill the 254-byte
// lookahead are only written to the history ring. A token reads its literal
// (S_LIT_RD, S_LIT), then per distance checks the bound (S_DNEXT) and compares
// bytes (S_RD, S_CMP) on the single two-read-port history ring; the search
// walks distances 1 to 254 nearest first and skips distances that cannot beat
// the best run. It then emits (S_EMIT) and holds the result (S_OUT) while
// out_stall is high. A four-entry queue keeps accepting items until full while the
// encoder searches or its result waits. A token is one result of up to three
// bytes; the flush step that finds nothing left returns raw and packed totals.
module escape_byte_lz_compressor
  import escb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        escape_write,
  input  logic [7:0]  escape_byte,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_count,
  output logic [7:0]  out_first,
  output logic [7:0]  out_second,
  output logic [7:0]  out_third,
  output logic        done_res,
  output logic [31:0] raw_total,
  output logic [31:0] packed_total,
  output logic        overflow
);

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  assign in_cmd.op   = op;
  assign in_cmd.data = data_byte;

  escb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_cmd   (in_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  escb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .escape_write (escape_write),
    .escape_byte  (escape_byte),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .cmd          (q_cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_count    (out_count),
    .out_first    (out_first),
    .out_second   (out_second),
    .out_third    (out_third),
    .done_res     (done_res),
    .raw_total    (raw_total),
    .packed_total (packed_total),
    .overflow     (overflow)
  );

endmodule
